// File: src/quoted_pair_line_unescaper_top_assert.svh
// Assertion macros shared by the checker of the quoted pair line unescaper.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef QUOTED_PAIR_LINE_UNESCAPER_TOP_ASSERT_SVH
`define QUOTED_PAIR_LINE_UNESCAPER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define QPLU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define QPLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/qplu_pkg.sv
// Package of the quoted pair line unescaper: item types, line state, codes.
// Character constants and the hex digit decoder. No dependencies.
package qplu_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] char_out;
    logic [3:0]  status;
    logic [15:0] key_length;
    logic [15:0] value_length;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  esc_step;
    logic [15:0] hex_acc;
    logic [15:0] key_count;
    logic [15:0] value_count;
    logic [3:0]  first_error;
  } line_state_t;

  localparam logic [2:0] PH_KEY_OPEN = 3'd0;
  localparam logic [2:0] PH_KEY      = 3'd1;
  localparam logic [2:0] PH_EQUALS   = 3'd2;
  localparam logic [2:0] PH_VAL_OPEN = 3'd3;
  localparam logic [2:0] PH_VALUE    = 3'd4;
  localparam logic [2:0] PH_TRAIL    = 3'd5;

  localparam logic [2:0] ESC_NONE = 3'd0;
  localparam logic [2:0] ESC_SEEN = 3'd1;
  localparam logic [2:0] ESC_HEX0 = 3'd2;
  localparam logic [2:0] ESC_HEX3 = 3'd5;

  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_NO_OPEN_QUOTE = 4'd1;
  localparam logic [3:0] ST_EMPTY_KEY     = 4'd2;
  localparam logic [3:0] ST_BAD_SEPARATOR = 4'd3;
  localparam logic [3:0] ST_BAD_ESCAPE    = 4'd4;
  localparam logic [3:0] ST_BAD_HEX       = 4'd5;
  localparam logic [3:0] ST_UNTERMINATED  = 4'd6;
  localparam logic [3:0] ST_TRAILING_JUNK = 4'd7;
  localparam logic [3:0] ST_KEY_TOO_LONG  = 4'd8;
  localparam logic [3:0] ST_VAL_TOO_LONG  = 4'd9;
  localparam logic [3:0] ST_LAST          = ST_VAL_TOO_LONG;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic CFG_KEY_CAP = 1'b0;
  localparam logic CFG_VAL_CAP = 1'b1;
  localparam logic [15:0] CAP_RESET = 16'd255;

  localparam logic [15:0] CH_QUOTE = 16'h0022;
  localparam logic [15:0] CH_BSL   = 16'h005C;
  localparam logic [15:0] CH_EQ    = 16'h003D;
  localparam logic [15:0] CH_N     = 16'h006E;
  localparam logic [15:0] CH_R     = 16'h0072;
  localparam logic [15:0] CH_T     = 16'h0074;
  localparam logic [15:0] CH_U     = 16'h0075;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_CR    = 16'h000D;

  // Returns {valid, digit} for a hex digit in either case.
  function automatic logic [4:0] hex_digit(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[16'h0030:16'h0039]}) begin
      r = {1'b1, 4'(c - 16'h0030)};
    end else if (c inside {[16'h0061:16'h0066]}) begin
      r = {1'b1, 4'(c - 16'h0057)};
    end else if (c inside {[16'h0041:16'h0046]}) begin
      r = {1'b1, 4'(c - 16'h0037)};
    end
    return r;
  endfunction

endpackage

// File: src/qplu_step.sv
// Per-item decode of the quoted pair line unescaper: next line state and result.
// Purely combinational; depends on qplu_pkg.
module qplu_step (
  input  qplu_pkg::line_state_t state_i,
  input  qplu_pkg::in_item_t    item_i,
  input  logic [15:0]           key_cap_i,
  input  logic [15:0]           val_cap_i,
  output qplu_pkg::line_state_t state_o,
  output logic                  res_valid_o,
  output qplu_pkg::out_item_t   res_o
);
  import qplu_pkg::*;

  line_state_t nxt;
  logic [15:0] cu;
  logic        dec;
  logic [15:0] dch;
  logic [4:0]  hd;
  logic [15:0] hex_new;
  logic        is_key;
  logic [15:0] cnt;
  logic [15:0] cap;
  logic        emit;

  assign cu      = item_i.code_unit;
  assign hd      = hex_digit(cu);
  assign hex_new = {state_i.hex_acc[11:0], hd[3:0]};
  assign is_key  = (state_i.phase == PH_KEY);
  assign cnt     = is_key ? state_i.key_count : state_i.value_count;
  assign cap     = is_key ? key_cap_i : val_cap_i;

  always_comb begin
    nxt  = state_i;
    dec  = 1'b0;
    dch  = cu;
    emit = 1'b0;
    if (state_i.first_error == ST_OK) begin
      case (state_i.phase)
        PH_KEY_OPEN: begin
          if (cu == CH_QUOTE) nxt.phase = PH_KEY;
          else nxt.first_error = ST_NO_OPEN_QUOTE;
        end
        PH_KEY, PH_VALUE: begin
          if (state_i.esc_step == ESC_NONE) begin
            if (cu == CH_BSL) begin
              nxt.esc_step = ESC_SEEN;
            end else if (cu == CH_QUOTE) begin
              if (is_key) begin
                if (state_i.key_count == 16'd0) nxt.first_error = ST_EMPTY_KEY;
                else nxt.phase = PH_EQUALS;
              end else begin
                nxt.phase = PH_TRAIL;
              end
            end else begin
              dec = 1'b1;
            end
          end else if (state_i.esc_step == ESC_SEEN) begin
            nxt.esc_step = ESC_NONE;
            case (cu)
              CH_QUOTE: dec = 1'b1;
              CH_BSL:   dec = 1'b1;
              CH_N: begin
                dec = 1'b1;
                dch = CH_LF;
              end
              CH_R: begin
                dec = 1'b1;
                dch = CH_CR;
              end
              CH_T: begin
                dec = 1'b1;
                dch = CH_TAB;
              end
              CH_U: begin
                nxt.esc_step = ESC_HEX0;
                nxt.hex_acc  = 16'd0;
              end
              default: nxt.first_error = ST_BAD_ESCAPE;
            endcase
          end else begin
            if (!hd[4]) begin
              nxt.first_error = ST_BAD_HEX;
              nxt.esc_step    = ESC_NONE;
            end else begin
              nxt.hex_acc = hex_new;
              if (state_i.esc_step >= ESC_HEX3) begin
                nxt.esc_step = ESC_NONE;
                dec = 1'b1;
                dch = hex_new;
              end else begin
                nxt.esc_step = 3'(state_i.esc_step + 3'd1);
              end
            end
          end
          if (dec) begin
            if (cnt >= cap) begin
              nxt.first_error = is_key ? ST_KEY_TOO_LONG : ST_VAL_TOO_LONG;
            end else if (!item_i.line_end) begin
              emit = 1'b1;
              if (is_key) nxt.key_count = 16'(state_i.key_count + 16'd1);
              else nxt.value_count = 16'(state_i.value_count + 16'd1);
            end
          end
        end
        PH_EQUALS: begin
          if (cu == CH_EQ) nxt.phase = PH_VAL_OPEN;
          else nxt.first_error = ST_BAD_SEPARATOR;
        end
        PH_VAL_OPEN: begin
          if (cu == CH_QUOTE) nxt.phase = PH_VALUE;
          else nxt.first_error = ST_BAD_SEPARATOR;
        end
        PH_TRAIL: begin
          if (cu != CH_SPACE && cu != CH_TAB) nxt.first_error = ST_TRAILING_JUNK;
        end
        default: begin
        end
      endcase
    end

    res_o       = '0;
    res_valid_o = 1'b0;
    state_o     = nxt;
    if (item_i.line_end) begin
      if (nxt.first_error == ST_OK) begin
        case (nxt.phase)
          PH_KEY, PH_VALUE:       nxt.first_error = ST_UNTERMINATED;
          PH_EQUALS, PH_VAL_OPEN: nxt.first_error = ST_BAD_SEPARATOR;
          PH_KEY_OPEN:            nxt.first_error = ST_NO_OPEN_QUOTE;
          default: begin
          end
        endcase
      end
      res_valid_o        = 1'b1;
      res_o.kind         = KIND_STATUS;
      res_o.status       = nxt.first_error;
      res_o.key_length   = nxt.key_count;
      res_o.value_length = nxt.value_count;
      state_o            = '0;
      state_o.phase      = PH_KEY_OPEN;
      state_o.esc_step   = ESC_NONE;
    end else if (emit) begin
      res_valid_o    = 1'b1;
      res_o.kind     = is_key ? KIND_KEY : KIND_VALUE;
      res_o.char_out = dch;
    end
  end

endmodule

// File: src/quoted_pair_line_unescaper_top.sv
// Top level of the quoted pair line unescaper: input register, line state,
// result register and capacity registers. Depends on qplu_pkg and qplu_step.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   in_item_i  (qplu_pkg::in_item_t)
//   out       output     out_valid_o / out_ready_i out_item_o (qplu_pkg::out_item_t)
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One item is taken every cycle unless the input channel stalls (see below).
// The line state is loaded from the input register through the combinational step.
// Reset clears the line state and sets both capacities to 255.
// An item that yields a result waits in the input register while the result
// register is full, which then stalls the input channel.
module quoted_pair_line_unescaper_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qplu_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qplu_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);
  import qplu_pkg::*;

  logic        in_valid_q;
  in_item_t    in_q;
  line_state_t state_q;
  line_state_t state_d;
  logic        out_valid_q;
  out_item_t   out_q;
  logic [15:0] key_cap_q;
  logic [15:0] val_cap_q;
  logic        res_valid;
  out_item_t   res;
  logic        out_free;
  logic        proc_go;

  qplu_step u_step (
    .state_i     (state_q),
    .item_i      (in_q),
    .key_cap_i   (key_cap_q),
    .val_cap_i   (val_cap_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc_go    = in_valid_q && (out_free || !res_valid);
  assign in_ready_o = !in_valid_q || proc_go;

  // The all-zero line state is the key opening quote phase with no escape pending.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      state_q           <= '0;
      out_valid_q       <= 1'b0;
      key_cap_q         <= CAP_RESET;
      val_cap_q         <= CAP_RESET;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (proc_go) state_q <= state_d;
      if (proc_go && res_valid) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_KEY_CAP) key_cap_q <= cfg_wdata_i;
        else if (cfg_idx_i == CFG_VAL_CAP) val_cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
    if (proc_go && res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: src/qplu_checker.sv
// Port-level checker of the quoted pair line unescaper, bound to the top level.
// Depends on qplu_pkg and quoted_pair_line_unescaper_top_assert.svh.
`include "quoted_pair_line_unescaper_top_assert.svh"

module qplu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input qplu_pkg::out_item_t out_item_o
);
  import qplu_pkg::*;

  `QPLU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "stalled result item changed or dropped")
  `QPLU_ASSERT_NOW(a_char_clean, out_valid_o && out_item_o.kind != KIND_STATUS, out_item_o.status == ST_OK && out_item_o.key_length == 16'd0 && out_item_o.value_length == 16'd0, "character item carries status fields")
  `QPLU_ASSERT_NOW(a_ok_has_key, out_valid_o && out_item_o.kind == KIND_STATUS && out_item_o.status == ST_OK, out_item_o.key_length != 16'd0, "ok status with an empty key")
  `QPLU_ASSERT_NOW(a_status_range, out_valid_o, out_item_o.status <= ST_LAST && out_item_o.kind != 2'd3, "result item field out of range")

endmodule

bind quoted_pair_line_unescaper_top qplu_checker u_qplu_checker (.*);

// File: tb/quoted_pair_line_unescaper_top_test.sv
// Testbench for quoted_pair_line_unescaper_top: directed and random lines are streamed in,
// and every result is checked against a line decoder kept inside the bench.
// Depends on qplu_pkg and the quoted_pair_line_unescaper_top RTL.
module quoted_pair_line_unescaper_top_test;
  import qplu_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PIPE_CYCLES    = 4;
  localparam logic [15:0] CH_ZERO        = 16'h0030;
  localparam logic [15:0] CH_LOW_A       = 16'h0061;
  localparam logic [15:0] CH_UP_A        = 16'h0041;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  logic [15:0] cap_key;
  logic [15:0] cap_value;
  logic [2:0]  ln_phase;
  logic [2:0]  ln_esc;
  logic [15:0] ln_hex;
  logic [15:0] ln_keys;
  logic [15:0] ln_values;
  logic [3:0]  ln_error;

  out_item_t   pending_results[$];
  out_item_t   want;
  logic [15:0] line_q[$];
  int unsigned fail_count  = 0;
  int unsigned sent_units  = 0;
  int unsigned idle_cycles = 0;
  bit          calm        = 1'b0;

  quoted_pair_line_unescaper_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_line_state();
    ln_phase  = PH_KEY_OPEN;
    ln_esc    = ESC_NONE;
    ln_hex    = 16'd0;
    ln_keys   = 16'd0;
    ln_values = 16'd0;
    ln_error  = ST_OK;
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [15:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 16'd9) return {1'b1, c[3:0]};
    if ((c >= CH_LOW_A && c <= CH_LOW_A + 16'd5) || (c >= CH_UP_A && c <= CH_UP_A + 16'd5))
      return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  task automatic decode_unit(input logic [15:0] cu, input logic last);
    logic        emit;
    logic        decoded;
    logic        is_key;
    logic [15:0] ch;
    logic [4:0]  nib;
    out_item_t   res;
    emit    = 1'b0;
    decoded = 1'b0;
    is_key  = 1'b0;
    ch      = 16'd0;
    res     = '0;
    sent_units++;
    if (ln_error == ST_OK) begin
      case (ln_phase)
        PH_KEY_OPEN: begin
          if (cu == CH_QUOTE) ln_phase = PH_KEY;
          else ln_error = ST_NO_OPEN_QUOTE;
        end
        PH_KEY, PH_VALUE: begin
          if (ln_esc == ESC_NONE) begin
            if (cu == CH_BSL) begin
              ln_esc = ESC_SEEN;
            end else if (cu == CH_QUOTE) begin
              if (ln_phase == PH_VALUE) ln_phase = PH_TRAIL;
              else if (ln_keys == 16'd0) ln_error = ST_EMPTY_KEY;
              else ln_phase = PH_EQUALS;
            end else begin
              ch      = cu;
              decoded = 1'b1;
            end
          end else if (ln_esc == ESC_SEEN) begin
            ln_esc  = ESC_NONE;
            decoded = 1'b1;
            case (cu)
              CH_QUOTE: ch = CH_QUOTE;
              CH_BSL:   ch = CH_BSL;
              CH_N:     ch = CH_LF;
              CH_R:     ch = CH_CR;
              CH_T:     ch = CH_TAB;
              CH_U: begin
                decoded = 1'b0;
                ln_esc  = ESC_HEX0;
                ln_hex  = 16'd0;
              end
              default: begin
                decoded  = 1'b0;
                ln_error = ST_BAD_ESCAPE;
              end
            endcase
          end else begin
            nib = hex_nibble(cu);
            if (!nib[4]) begin
              ln_error = ST_BAD_HEX;
              ln_esc   = ESC_NONE;
            end else begin
              ln_hex = {ln_hex[11:0], nib[3:0]};
              if (ln_esc >= ESC_HEX3) begin
                ln_esc  = ESC_NONE;
                ch      = ln_hex;
                decoded = 1'b1;
              end else begin
                ln_esc = ln_esc + 3'd1;
              end
            end
          end
          if (decoded) begin
            is_key = (ln_phase == PH_KEY);
            if (is_key ? (ln_keys >= cap_key) : (ln_values >= cap_value)) begin
              ln_error = is_key ? ST_KEY_TOO_LONG : ST_VAL_TOO_LONG;
            end else if (!last) begin
              if (is_key) ln_keys++;
              else ln_values++;
              emit = 1'b1;
            end
          end
        end
        PH_EQUALS: begin
          if (cu == CH_EQ) ln_phase = PH_VAL_OPEN;
          else ln_error = ST_BAD_SEPARATOR;
        end
        PH_VAL_OPEN: begin
          if (cu == CH_QUOTE) ln_phase = PH_VALUE;
          else ln_error = ST_BAD_SEPARATOR;
        end
        PH_TRAIL: begin
          if (cu != CH_SPACE && cu != CH_TAB) ln_error = ST_TRAILING_JUNK;
        end
        default: ;
      endcase
    end
    if (last) begin
      if (ln_error == ST_OK) begin
        if (ln_phase == PH_KEY || ln_phase == PH_VALUE) ln_error = ST_UNTERMINATED;
        else if (ln_phase == PH_EQUALS || ln_phase == PH_VAL_OPEN) ln_error = ST_BAD_SEPARATOR;
        else if (ln_phase == PH_KEY_OPEN) ln_error = ST_NO_OPEN_QUOTE;
      end
      res.kind         = KIND_STATUS;
      res.status       = ln_error;
      res.key_length   = ln_keys;
      res.value_length = ln_values;
      pending_results.push_back(res);
      clear_line_state();
    end else if (emit) begin
      res.kind     = is_key ? KIND_KEY : KIND_VALUE;
      res.char_out = ch;
      pending_results.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("%0t: %s: got %h, expected %h", $time, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, kind", 16'(out_item_o.kind), 16'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.kind != want.kind)
          report_mismatch("kind", 16'(out_item_o.kind), 16'(want.kind));
        if (out_item_o.char_out != want.char_out)
          report_mismatch("char_out", out_item_o.char_out, want.char_out);
        if (out_item_o.status != want.status)
          report_mismatch("status", 16'(out_item_o.status), 16'(want.status));
        if (out_item_o.key_length != want.key_length)
          report_mismatch("key_length", out_item_o.key_length, want.key_length);
        if (out_item_o.value_length != want.value_length)
          report_mismatch("value_length", out_item_o.value_length, want.value_length);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : ready_driver
    int unsigned stall;
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 7);
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_item(input logic [15:0] cu, input logic last);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i          = 1'b1;
    in_item_i.code_unit = cu;
    in_item_i.line_end  = last;
    do @(posedge clk_i); while (!in_ready_o);
    decode_unit(cu, last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_item(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back({8'h00, s[i]});
  endtask

  task automatic send_text(input string s);
    line_q.delete();
    load_text(s);
    send_line();
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle_block();
    drain_results();
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacities(input logic [15:0] kcap, input logic [15:0] vcap);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_KEY_CAP;
    cfg_wdata_i = kcap;
    @(negedge clk_i);
    cfg_idx_i   = CFG_VAL_CAP;
    cfg_wdata_i = vcap;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cap_key     = kcap;
    cap_value   = vcap;
  endtask

  function automatic logic [15:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return CH_ZERO + 16'(d);
    return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 16'(d) - 16'd10;
  endfunction

  function automatic logic [15:0] plain_unit();
    logic [15:0] c;
    if ($urandom_range(0, 3) == 0) c = 16'($urandom_range(0, 65535));
    else c = 16'($urandom_range(32, 126));
    if (c == CH_QUOTE || c == CH_BSL) c = CH_EQ;
    return c;
  endfunction

  function automatic logic [15:0] odd_unit();
    case ($urandom_range(0, 8))
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return CH_EQ;
      3: return CH_SPACE;
      4: return CH_TAB;
      5: return CH_U;
      6: return CH_LOW_A + 16'($urandom_range(0, 25));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int unsigned string_length(input int unsigned shortest);
    if ($urandom_range(0, 39) == 0) return $urandom_range(250, 260);
    return $urandom_range(shortest, 6);
  endfunction

  task automatic add_escape();
    line_q.push_back(CH_BSL);
    case ($urandom_range(0, 5))
      0: line_q.push_back(CH_QUOTE);
      1: line_q.push_back(CH_BSL);
      2: line_q.push_back(CH_N);
      3: line_q.push_back(CH_R);
      4: line_q.push_back(CH_T);
      default: begin
        line_q.push_back(CH_U);
        repeat (4) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
    endcase
  endtask

  task automatic add_body(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) add_escape();
      else line_q.push_back(plain_unit());
    end
  endtask

  task automatic build_random_line();
    int unsigned pick;
    int unsigned pos;
    line_q.delete();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 6)) line_q.push_back(odd_unit());
    end else begin
      line_q.push_back(CH_QUOTE);
      add_body(string_length(1));
      line_q.push_back(CH_QUOTE);
      line_q.push_back(CH_EQ);
      line_q.push_back(CH_QUOTE);
      add_body(string_length(0));
      line_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 2)) line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      if (pick <= 2) begin
        pos = $urandom_range(0, line_q.size() - 1);
        case ($urandom_range(0, 2))
          0: line_q[pos] = odd_unit();
          1: while (line_q.size() > pos + 1) line_q.delete(line_q.size() - 1);
          default: line_q.insert(pos, odd_unit());
        endcase
      end
    end
  endtask

  task automatic run_random_lines(input logic [15:0] kcap, input logic [15:0] vcap,
                                  input int unsigned units, input bit no_idle);
    int unsigned target;
    settle_block();
    write_capacities(kcap, vcap);
    calm   = no_idle;
    target = sent_units + units;
    while (sent_units < target) begin
      build_random_line();
      send_line();
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic test_escapes_and_extremes();
    line_q.delete();
    load_text("\"\\u0aFf");
    line_q.push_back(16'hFFFF);
    line_q.push_back(16'h0000);
    load_text("\"=\"\\\"\\\\\\n\\r\\t\" ");
    send_line();
  endtask

  task automatic test_line_errors();
    string lines [9];
    lines = '{"x", "\"\"", "\"k\"=x", "\"k\"", "\"\\q", "\"\\u1\"", "\"\\", "\"k",
              "\"k\"=\"\" x"};
    foreach (lines[i]) send_text(lines[i]);
  endtask

  task automatic test_capacity_limits();
    settle_block();
    write_capacities(16'd0, 16'd0);
    send_text("\"k\"=\"v\"");
    settle_block();
    write_capacities(16'd1, 16'd0);
    send_text("\"k\"=\"v\"");
    send_text("\"a\\u0041\"");
    send_text("\"k\"=\"\"");
  endtask

  task automatic test_random_wide_capacity();
    run_random_lines(16'hFFFF, 16'hFFFF, 500, 1'b0);
  endtask

  task automatic test_random_tight_capacity();
    run_random_lines(16'd3, 16'd2, 400, 1'b0);
  endtask

  task automatic test_random_drawn_capacity();
    run_random_lines(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)), 500, 1'b0);
  endtask

  task automatic test_random_no_stalls();
    run_random_lines(CAP_RESET, CAP_RESET, 600, 1'b1);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_KEY_CAP;
    cfg_wdata_i = 16'd0;
    cap_key     = CAP_RESET;
    cap_value   = CAP_RESET;
    clear_line_state();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_escapes_and_extremes();
    test_line_errors();
    test_capacity_limits();
    test_random_wide_capacity();
    test_random_tight_capacity();
    test_random_drawn_capacity();
    test_random_no_stalls();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
